FILE: rtl/bba_pkg.sv
// bba_pkg: shared constants, command/status types and helper for the bitmap block allocator
// no dependencies; imported by the interfaces and every rtl module
`timescale 1ns / 1ps

package bba_pkg;

    // default bitmap size and the range a block number can name
    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int ADDR_BLOCKS    = 4096;
    localparam int WORD_BITS      = 64;

    // field widths
    localparam int ACTION_W = 1;
    localparam int BLOCK_W  = 12;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 13;
    localparam int WORDS_W  = 7;

    // reset value of total_blocks
    localparam logic [COUNT_W-1:0] TOTAL_RESET = 13'd4096;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic                load;       // capture request and effective count
        logic                rd_start;   // read word 0, scan counter to 1
        logic                rd_scan;    // read word at scan counter, advance
        logic                rd_blk;     // read the word holding the request block
        logic                wr_set;     // mark the found free bit used
        logic                wr_clr;     // clear the request block bit
        logic                res_load;   // latch a result
        logic [STATUS_W-1:0] res_status;
        logic                res_grant;  // result carries the found block number
        logic                out_load;   // move result into output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_free;    // captured action is a free
        logic no_words;   // effective count is zero
        logic blk_range;  // request block at or above the effective count
        logic hit;        // word under test has a free bit below the count
        logic last_word;  // word under test is the last covered word
        logic bit_used;   // request block bit is set
        logic out_free;   // output register can take a result this cycle
    } t_sts;

    // lowest set bit position, 63 when none is set
    function automatic logic [5:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [5:0] pos;
        pos = 6'd63;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: rtl/bba_cfg_if.sv
// bba_cfg_if: configuration write channel carrying total_blocks
// depends on bba_pkg
`timescale 1ns / 1ps

interface bba_cfg_if;
    import bba_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] total_blocks;

    modport source (output valid, output total_blocks, input ready);
    modport sink   (input valid, input total_blocks, output ready);
endinterface

FILE: rtl/bba_req_if.sv
// bba_req_if: request channel carrying action and block_number
// depends on bba_pkg
`timescale 1ns / 1ps

interface bba_req_if;
    import bba_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BLOCK_W-1:0]  block_number;

    modport source (output valid, output action, output block_number, input ready);
    modport sink   (input valid, input action, input block_number, output ready);
endinterface

FILE: rtl/bba_rsp_if.sv
// bba_rsp_if: result channel carrying status and granted_block
// depends on bba_pkg
`timescale 1ns / 1ps

interface bba_rsp_if;
    import bba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  granted_block;

    modport source (output valid, output status, output granted_block, input ready);
    modport sink   (input valid, input status, input granted_block, output ready);
endinterface

FILE: rtl/bitmap_block_allocator.sv
// bitmap_block_allocator: first-fit block allocator over a used/free bitmap
// depends on bba_pkg, bba_cfg_if, bba_req_if, bba_rsp_if, bba_ctrl, bba_datapath
//
//   channel  dir  payload                   transfer
//   i_cfg    in   total_blocks (13b)        valid & ready, ready always high
//   i_req    in   action, block_number      valid & ready, ready while idle
//   o_rsp    out  status, granted_block     valid & ready, one per request
//
// a free goes through dispatch, a read of the word holding its block and finish before
// the next ready, skipping the read when out of range; an allocate reads k 64-bit bitmap
// words, one per cycle on the memory read port, k at most 64 at 4096 blocks.
// reset clears the per-word valid bits: every block reads as free, no sweep.
// a held result in the output register does not block the next request; only a
// second finished result waits for it.
`timescale 1ns / 1ps

module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bba_cfg_if.sink   i_cfg,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp
);
    import bba_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;

    // controller
    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    // datapath
    bba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_data      (i_cfg.total_blocks),
        .i_action        (i_req.action),
        .i_block_number  (i_req.block_number),
        .i_out_ready     (o_rsp.ready),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_granted_block (o_rsp.granted_block)
    );

endmodule

FILE: rtl/bba_datapath.sv
// bba_datapath: bitmap memory with per-word valid bits, scan counter, result and output registers
// depends on bba_pkg; driven by bba_ctrl through t_cmd, reports through t_sts
`timescale 1ns / 1ps

module bba_datapath #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::COUNT_W-1:0]   i_cfg_data,
    input  logic [bba_pkg::ACTION_W-1:0]  i_action,
    input  logic [bba_pkg::BLOCK_W-1:0]   i_block_number,
    input  logic                          i_out_ready,
    input  bba_pkg::t_cmd                 i_cmd,
    output bba_pkg::t_sts                 o_sts,
    output logic                          o_out_valid,
    output logic [bba_pkg::STATUS_W-1:0]  o_status,
    output logic [bba_pkg::BLOCK_W-1:0]   o_granted_block
);
    import bba_pkg::*;

    localparam int CAP   = (NUM_BLOCKS < ADDR_BLOCKS) ? NUM_BLOCKS : ADDR_BLOCKS;
    localparam int WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAP);

    // configuration register
    logic [COUNT_W-1:0] r_total;

    // captured request
    logic [ACTION_W-1:0] r_action;
    logic [BLOCK_W-1:0]  r_blk;
    logic [COUNT_W-1:0]  r_count;
    logic [WORDS_W-1:0]  r_words;

    // scan and memory read side
    logic [AW:0]            r_cnt;
    logic [AW-1:0]          r_rdword;
    logic [WORD_BITS-1:0]   r_rdata;
    logic [WORD_BITS-1:0]   r_mem [WORDS];
    logic [WORDS-1:0]       r_wvalid;

    // result and output registers
    logic [STATUS_W-1:0] r_res_status;
    logic [BLOCK_W-1:0]  r_res_grant;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [BLOCK_W-1:0]  r_out_grant;

    logic [COUNT_W-1:0]   eff_count;
    logic [COUNT_W:0]     words_sum;
    logic [AW-1:0]        blk_word;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic [WORDS_W-1:0]   last_idx;
    logic                 is_last;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] avail;
    logic [5:0]           found_bit;
    logic [WORD_BITS-1:0] blk_mask;
    logic [WORD_BITS-1:0] found_mask;

    // effective count, saturated to the bitmap size
    assign eff_count = (r_total > CAP_C) ? CAP_C : r_total;
    assign words_sum = {1'b0, eff_count} + (COUNT_W + 1)'(WORD_BITS - 1);

    // word under test and its valid-bit mask
    assign blk_word = r_blk[AW+5:6];
    assign last_idx = r_words - WORDS_W'(1);
    assign is_last  = (WORDS_W'(r_rdword) == last_idx);
    always_comb begin
        if (!is_last || (r_count[5:0] == 6'd0)) begin
            mask = '1;
        end else begin
            mask = (WORD_BITS'(1) << r_count[5:0]) - WORD_BITS'(1);
        end
    end
    assign avail      = ~r_rdata & mask;
    assign found_bit  = lowest_set(avail);
    assign found_mask = WORD_BITS'(1) << found_bit;
    assign blk_mask   = WORD_BITS'(1) << r_blk[5:0];

    // read address select
    always_comb begin
        rd_en   = i_cmd.rd_start | i_cmd.rd_scan | i_cmd.rd_blk;
        rd_addr = '0;
        if (i_cmd.rd_scan) begin
            rd_addr = r_cnt[AW-1:0];
        end else if (i_cmd.rd_blk) begin
            rd_addr = blk_word;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.is_free   = (r_action == ACT_FREE);
        o_sts.no_words  = (r_words == '0);
        o_sts.blk_range = ({1'b0, r_blk} >= r_count);
        o_sts.hit       = (avail != '0);
        o_sts.last_word = is_last;
        o_sts.bit_used  = r_rdata[r_blk[5:0]];
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
        end else if (i_cfg_we) begin
            r_total <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_blk    <= i_block_number;
            r_count  <= eff_count;
            r_words  <= words_sum[WORDS_W+5:6];
        end
    end

    // scan counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_cnt <= (AW + 1)'(1);
        end else if (i_cmd.rd_scan) begin
            r_cnt <= r_cnt + (AW + 1)'(1);
        end
    end

    // bitmap memory read, unwritten words read as free
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdword <= rd_addr;
            if (({1'b0, rd_addr} < (AW + 1)'(WORDS)) && r_wvalid[rd_addr]) begin
                r_rdata <= r_mem[rd_addr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    // bitmap memory write
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_set) begin
            r_mem[r_rdword] <= r_rdata | found_mask;
        end else if (i_cmd.wr_clr) begin
            r_mem[r_rdword] <= r_rdata & ~blk_mask;
        end
    end

    // per-word valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (i_cmd.wr_set || i_cmd.wr_clr) begin
            r_wvalid[r_rdword] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_grant  <= i_cmd.res_grant ? {6'(r_rdword), found_bit} : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_grant  <= r_res_grant;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_block = r_out_grant;

endmodule

FILE: rtl/bba_ctrl.sv
// bba_ctrl: sequencing state machine for allocate scans and free checks
// depends on bba_pkg; commands bba_datapath through t_cmd
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  bba_pkg::t_sts i_sts,
    output logic          o_req_ready,
    output bba_pkg::t_cmd o_cmd
);
    import bba_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_FREE_CHK = 3'd3;
    localparam logic [2:0] S_FIN      = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.is_free) begin
                    if (i_sts.blk_range) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_RANGE;
                        n_state          = S_FIN;
                    end else begin
                        o_cmd.rd_blk = 1'b1;
                        n_state      = S_FREE_CHK;
                    end
                end else if (i_sts.no_words) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_FULL;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.wr_set     = 1'b1;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_grant  = 1'b1;
                    n_state          = S_FIN;
                end else if (i_sts.last_word) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_FULL;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                end
            end
            S_FREE_CHK: begin
                o_cmd.res_load = 1'b1;
                if (i_sts.bit_used) begin
                    o_cmd.wr_clr     = 1'b1;
                    o_cmd.res_status = ST_OK;
                end else begin
                    o_cmd.res_status = ST_ALREADY_FREE;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
